// ----- src/cbc_pkg.sv -----
package cbc_pkg;

    // One bus access from the processor side
    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [7:0]  data;
    } req_t;

    typedef enum logic [2:0] {
        TGT_NONE  = 3'd0,
        TGT_ROM   = 3'd1,
        TGT_RAM   = 3'd2,
        TGT_CLOCK = 3'd3,
        TGT_OPEN  = 3'd4
    } target_t;

    // One mapped result toward the cartridge side
    typedef struct packed {
        target_t     target;
        logic [22:0] rom_address;
        logic [16:0] ram_address;
        logic        ram_write;
        logic [7:0]  read_data;
    } rsp_t;

    typedef logic [2:0] kind_t;

    localparam kind_t MAP_NONE = 3'd0;
    localparam kind_t MAP_MBC1 = 3'd1;
    localparam kind_t MAP_MBC2 = 3'd2;
    localparam kind_t MAP_MBC3 = 3'd3;
    localparam kind_t MAP_MBC5 = 3'd4;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int CLK_REG_COUNT = 5;
    localparam logic [2:0] CLK_IDX_DH   = 3'd4;
    localparam logic [7:0] CLK_DH_MASK  = 8'hC1;
    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [7:0] LATCH_ARM    = 8'h00;
    localparam logic [7:0] LATCH_FIRE   = 8'h01;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;

    // Write window decode inside 0000-7FFF (address bits 14:13)
    localparam logic [1:0] WIN_RAM_EN   = 2'b00;
    localparam logic [1:0] WIN_ROM_BANK = 2'b01;
    localparam logic [1:0] WIN_RAM_BANK = 2'b10;
    localparam logic [1:0] WIN_MODE     = 2'b11;

    // A000-BFFF: top three address bits
    localparam logic [2:0] CART_RAM_PAGE = 3'b101;

endpackage

// ----- src/cbc_chan_if.sv -----
interface cbc_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/cbc_in_stage.sv -----
module cbc_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    cbc_chan_if.sink      access,
    input  logic          advance,
    output logic          item_valid,
    output cbc_pkg::req_t item
);
    logic          valid_reg;
    logic          valid_next;
    cbc_pkg::req_t item_reg;
    logic          take;

    assign access.ready = !valid_reg || advance;
    assign take         = access.valid && access.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= access.payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ----- src/cbc_mapper.sv -----
module cbc_mapper (
    input  logic          clk,
    input  logic          rst_n,
    cbc_chan_if.sink      cfg,
    input  logic          fire,
    input  cbc_pkg::req_t item,
    output cbc_pkg::rsp_t result
);
    cbc_pkg::kind_t kind_reg;
    logic [8:0]     rom_bank_reg;
    logic [8:0]     rom_bank_next;
    logic [3:0]     ram_bank_reg;
    logic [3:0]     ram_bank_next;
    logic           ram_en_reg;
    logic           ram_en_next;
    logic           mode_reg;
    logic           mode_next;
    logic           clk_sel_reg;
    logic           clk_sel_next;
    logic [2:0]     clk_idx_reg;
    logic [2:0]     clk_idx_next;
    logic [7:0]     last_latch_reg;
    logic [7:0]     last_latch_next;
    logic [7:0]     clk_regs_reg [cbc_pkg::CLK_REG_COUNT];
    logic [7:0]     clk_regs_next [cbc_pkg::CLK_REG_COUNT];
    logic [7:0]     clk_latched_reg [cbc_pkg::CLK_REG_COUNT];
    logic           do_latch;
    logic [8:0]     bank_tmp;
    logic           kind_ok;
    logic           clock_path;
    logic           in_cart_ram;
    logic [15:0]    a;
    logic [7:0]     d;

    assign cfg.ready   = 1'b1;
    assign a           = item.address;
    assign d           = item.data;
    assign kind_ok     = (kind_reg >= cbc_pkg::MAP_MBC1) && (kind_reg <= cbc_pkg::MAP_MBC5);
    assign clock_path  = (kind_reg == cbc_pkg::MAP_MBC3) && clk_sel_reg;
    assign in_cart_ram = (a[15:13] == cbc_pkg::CART_RAM_PAGE);

    // Bank register writes below 8000, and clock register writes at A000-BFFF
    always_comb
    begin
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        ram_en_next     = ram_en_reg;
        mode_next       = mode_reg;
        clk_sel_next    = clk_sel_reg;
        clk_idx_next    = clk_idx_reg;
        last_latch_next = last_latch_reg;
        do_latch        = 1'b0;
        bank_tmp        = rom_bank_reg;
        for (int i = 0; i < cbc_pkg::CLK_REG_COUNT; i++)
        begin
            clk_regs_next[i] = clk_regs_reg[i];
        end

        if (item.op == cbc_pkg::OP_WRITE && !a[15] && kind_ok)
        begin
            case (a[14:13])
                cbc_pkg::WIN_RAM_EN:
                begin
                    if (!(kind_reg == cbc_pkg::MAP_MBC2 && a[8]))
                    begin
                        ram_en_next = (d[3:0] == cbc_pkg::RAM_EN_KEY);
                    end
                end
                cbc_pkg::WIN_ROM_BANK:
                begin
                    if (kind_reg == cbc_pkg::MAP_MBC5)
                    begin
                        if (!a[12])
                        begin
                            rom_bank_next = {rom_bank_reg[8], d};
                        end
                        else
                        begin
                            rom_bank_next = {d[0], rom_bank_reg[7:0]};
                        end
                    end
                    else
                    begin
                        if (kind_reg == cbc_pkg::MAP_MBC2)
                        begin
                            bank_tmp = {5'd0, d[3:0]};
                        end
                        else if (kind_reg == cbc_pkg::MAP_MBC3)
                        begin
                            bank_tmp = {2'd0, d[6:0]};
                        end
                        else
                        begin
                            bank_tmp = {1'b0, rom_bank_reg[7:5], d[4:0]};
                        end
                        rom_bank_next = (bank_tmp == 9'd0) ? 9'd1 : bank_tmp;
                    end
                end
                cbc_pkg::WIN_RAM_BANK:
                begin
                    if (kind_reg == cbc_pkg::MAP_MBC1)
                    begin
                        if (mode_reg)
                        begin
                            bank_tmp      = {2'd0, d[1:0], rom_bank_reg[4:0]};
                            rom_bank_next = (bank_tmp == 9'd0) ? 9'd1 : bank_tmp;
                        end
                        else
                        begin
                            ram_bank_next = {2'd0, d[1:0]};
                        end
                    end
                    else if (kind_reg == cbc_pkg::MAP_MBC3)
                    begin
                        if (d inside {[8'h00:8'h03]})
                        begin
                            ram_bank_next = {2'd0, d[1:0]};
                            clk_sel_next  = 1'b0;
                        end
                        else if (d inside {[8'h08:8'h0C]})
                        begin
                            // 08-0C map to clock registers 0-4
                            clk_sel_next = 1'b1;
                            clk_idx_next = d[2:0];
                        end
                    end
                    else if (kind_reg == cbc_pkg::MAP_MBC5)
                    begin
                        ram_bank_next = d[3:0];
                    end
                end
                cbc_pkg::WIN_MODE:
                begin
                    if (kind_reg == cbc_pkg::MAP_MBC1)
                    begin
                        mode_next = !d[0];
                        if (!d[0])
                        begin
                            ram_bank_next = 4'd0;
                        end
                    end
                    else if (kind_reg == cbc_pkg::MAP_MBC3)
                    begin
                        do_latch        = (last_latch_reg == cbc_pkg::LATCH_ARM) &&
                                          (d == cbc_pkg::LATCH_FIRE);
                        last_latch_next = d;
                    end
                end
                default:
                begin
                    rom_bank_next = rom_bank_reg;
                end
            endcase
        end

        // Clock register write through the A000-BFFF window
        if (item.op == cbc_pkg::OP_WRITE && in_cart_ram && ram_en_reg && clock_path)
        begin
            if (clk_idx_reg == cbc_pkg::CLK_IDX_DH)
            begin
                clk_regs_next[cbc_pkg::CLK_IDX_DH] = d & cbc_pkg::CLK_DH_MASK;
            end
            else if (clk_idx_reg < cbc_pkg::CLK_IDX_DH)
            begin
                clk_regs_next[clk_idx_reg] = d;
            end
        end
    end

    // Result for the current item, from state before its own update
    always_comb
    begin
        result             = '0;
        result.target      = cbc_pkg::TGT_NONE;
        if (item.op == cbc_pkg::OP_WRITE)
        begin
            if (in_cart_ram && ram_en_reg)
            begin
                if (clock_path)
                begin
                    result.target = cbc_pkg::TGT_CLOCK;
                end
                else
                begin
                    result.target      = cbc_pkg::TGT_RAM;
                    result.ram_address = {ram_bank_reg, a[12:0]};
                    result.ram_write   = 1'b1;
                end
            end
        end
        else
        begin
            if (!a[15])
            begin
                result.target = cbc_pkg::TGT_ROM;
                if (!a[14])
                begin
                    result.rom_address = {7'd0, a};
                end
                else
                begin
                    result.rom_address = {rom_bank_reg, a[13:0]};
                end
            end
            else if (in_cart_ram)
            begin
                if (!ram_en_reg)
                begin
                    result.target    = cbc_pkg::TGT_OPEN;
                    result.read_data = cbc_pkg::OPEN_BUS;
                end
                else if (clock_path)
                begin
                    result.target = cbc_pkg::TGT_CLOCK;
                    if (clk_idx_reg <= cbc_pkg::CLK_IDX_DH)
                    begin
                        result.read_data = clk_latched_reg[clk_idx_reg];
                    end
                end
                else
                begin
                    result.target      = cbc_pkg::TGT_RAM;
                    result.ram_address = {ram_bank_reg, a[12:0]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= cbc_pkg::MAP_NONE;
            rom_bank_reg   <= 9'd1;
            ram_bank_reg   <= 4'd0;
            ram_en_reg     <= 1'b0;
            mode_reg       <= 1'b1;
            clk_sel_reg    <= 1'b0;
            clk_idx_reg    <= 3'd0;
            last_latch_reg <= 8'd0;
            for (int i = 0; i < cbc_pkg::CLK_REG_COUNT; i++)
            begin
                clk_regs_reg[i]    <= 8'd0;
                clk_latched_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                kind_reg <= cfg.payload;
            end
            if (fire)
            begin
                rom_bank_reg   <= rom_bank_next;
                ram_bank_reg   <= ram_bank_next;
                ram_en_reg     <= ram_en_next;
                mode_reg       <= mode_next;
                clk_sel_reg    <= clk_sel_next;
                clk_idx_reg    <= clk_idx_next;
                last_latch_reg <= last_latch_next;
                for (int i = 0; i < cbc_pkg::CLK_REG_COUNT; i++)
                begin
                    clk_regs_reg[i] <= clk_regs_next[i];
                    if (do_latch)
                    begin
                        clk_latched_reg[i] <= clk_regs_reg[i];
                    end
                end
            end
        end
    end
endmodule

// ----- src/cbc_out_stage.sv -----
module cbc_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  cbc_pkg::rsp_t result_in,
    output logic          advance,
    cbc_chan_if.source    result
);
    logic          valid_reg;
    logic          valid_next;
    cbc_pkg::rsp_t data_reg;

    assign advance = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= result_in;
        end
    end

    assign result.valid   = valid_reg;
    assign result.payload = data_reg;
endmodule

// ----- src/cartridge_bank_controller.sv -----
// Cartridge bank controller: maps processor bus accesses onto cartridge
// ROM, cartridge RAM or the clock registers of the selected mapper kind.
//
// Channels:
//   access  - one transfer per bus access (op, address, data).
//   result  - one transfer per access (target, rom_address, ram_address,
//             ram_write, read_data), in access order.
//   cfg     - mapper kind write; always ready. Write only while idle.
// Path: an access passes through the input register and then the result
// register, from which it is offered on the result channel.
// Throughput: one access per cycle while result is not held off; bank
// state written by one access is seen by the very next one, since decode
// and update happen in the same cycle.
// Stall: when result is held off, the result register keeps its transfer
// and the input register still takes one more access; access.ready drops
// only when both registers are full.
// Reset: both stages empty; mapper kind none, ROM bank 1, RAM bank 0,
// RAM disabled, ROM banking mode, clock registers and latch copies zero.
module cartridge_bank_controller (
    input  logic       clk,
    input  logic       rst_n,
    cbc_chan_if.sink   access,
    cbc_chan_if.source result,
    cbc_chan_if.sink   cfg
);
    logic          item_valid;
    cbc_pkg::req_t item;
    cbc_pkg::rsp_t mapped;
    logic          advance;
    logic          fire;

    // Item moves from input register to result register
    assign fire = item_valid && advance;

    cbc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .access     (access),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Bank state and address decode, updated on each fire
    cbc_mapper u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (item),
        .result (mapped)
    );

    cbc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .result_in (mapped),
        .advance   (advance),
        .result    (result)
    );
endmodule

// ----- src/cbc_checker.sv -----
module cbc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input cbc_pkg::rsp_t out_payload
);
    // A held result keeps its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");

    // A newly offered result is checked against an earlier access transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching access");

    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.ram_write |-> out_payload.target == cbc_pkg::TGT_RAM)
        else $error("RAM write strobe outside RAM target");

    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.target == cbc_pkg::TGT_OPEN
            |-> out_payload.read_data == cbc_pkg::OPEN_BUS)
        else $error("open bus read not 0xFF");

    a_ram_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.target != cbc_pkg::TGT_RAM
            |-> out_payload.ram_address == 17'd0)
        else $error("RAM address set on non-RAM result");
endmodule

bind cartridge_bank_controller cbc_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (access.valid),
    .in_ready    (access.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);
